FILE: rtl/azpm_pkg.sv
// azpm_pkg: shared types, widths, term codes and tables for the alt-az
// pointing-model correction core. No dependencies.
package azpm_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 20;
  localparam int CORDIC_STEPS_DEF    = 24;

  // datapath widths
  localparam int ACC_W  = 36;              // term value held between multiplies
  localparam int T_W    = 34;              // cordic x, y, z and trig values
  localparam int NUM_W  = 66;              // signed dividend
  localparam int DEN_W  = 34;              // divisor magnitude
  localparam int DM_W   = NUM_W + 1;       // dividend magnitude plus rounding half
  localparam int Q_W    = DM_W + 1;        // signed quotient
  localparam int P_W    = ACC_W + 1 + T_W; // product
  localparam int SUM_W  = 40;
  localparam int DC_W   = $clog2(DM_W);
  localparam int MC_W   = $clog2(T_W);

  localparam logic signed [T_W-1:0] CORDIC_X0 = T_W'(32'h26DD3B6A);
  localparam logic [DEN_W-1:0] COEF_DIV  = DEN_W'(32'd235929600); // 3600 * 2^16
  localparam logic [DEN_W-1:0] PHASE_DIV = DEN_W'(32'd360);

  // term kinds
  localparam logic [3:0] K_IE   = 4'd0;
  localparam logic [3:0] K_IA   = 4'd1;
  localparam logic [3:0] K_CA   = 4'd2;
  localparam logic [3:0] K_AN   = 4'd3;
  localparam logic [3:0] K_AW   = 4'd4;
  localparam logic [3:0] K_NPAE = 4'd5;
  localparam logic [3:0] K_TF   = 4'd6;
  localparam logic [3:0] K_TX   = 4'd7;
  localparam logic [3:0] K_TXL  = 4'd8;
  localparam logic [3:0] K_TX5  = 4'd9;
  localparam logic [3:0] K_TX10 = 4'd10;
  localparam logic [3:0] K_TX15 = 4'd11;
  localparam logic [3:0] K_HARM = 4'd12;

  // harmonic targets
  localparam logic [1:0] TGT_AZ   = 2'd0;
  localparam logic [1:0] TGT_EL   = 2'd1;
  localparam logic [1:0] TGT_SIDE = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  // trig operand select
  localparam logic [2:0] TS_SA = 3'd0;
  localparam logic [2:0] TS_CA = 3'd1;
  localparam logic [2:0] TS_SE = 3'd2;
  localparam logic [2:0] TS_CE = 3'd3;
  localparam logic [2:0] TS_H1 = 3'd4;
  localparam logic [2:0] TS_H2 = 3'd5;

  // one evaluation pass: multiplies, negate, optional divide, then accumulate
  typedef struct packed {
    logic       en;
    logic       m1_en;
    logic [2:0] m1_sel;
    logic       m2_en;
    logic [2:0] m2_sel;
    logic       neg;
    logic       div_en;
    logic       div_se;   // divide by sin el, else cos el
    logic       to_el;
    logic       more;     // a second pass follows
  } pass_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // elevation floor in degrees for the limited tube-flexure kinds
  function automatic logic [3:0] tx_floor_deg(input logic [3:0] kind);
    logic [3:0] d;
    case (kind)
      K_TX5:   d = 4'd5;
      K_TX10:  d = 4'd10;
      default: d = 4'd15;
    endcase
    return d;
  endfunction

  function automatic pass_t pass_plan(input logic [3:0] kind, input logic pass_idx,
                                      input logic guard, input logic tx_ok,
                                      input logic [1:0] target, input logic f2_on);
    pass_t p;
    p = '0;
    case (kind)
      K_IE: begin
        p.en = 1'b1; p.to_el = 1'b1;
      end
      K_IA: begin
        p.en = 1'b1; p.neg = 1'b1;
      end
      K_CA: begin
        p.en = guard; p.neg = 1'b1; p.div_en = 1'b1;
      end
      K_AN: begin
        if (!pass_idx) begin
          p.en = guard; p.m1_en = 1'b1; p.m1_sel = TS_SA; p.m2_en = 1'b1;
          p.m2_sel = TS_SE; p.neg = 1'b1; p.div_en = 1'b1; p.more = 1'b1;
        end else begin
          p.en = 1'b1; p.m1_en = 1'b1; p.m1_sel = TS_CA; p.neg = 1'b1; p.to_el = 1'b1;
        end
      end
      K_AW: begin
        if (!pass_idx) begin
          p.en = guard; p.m1_en = 1'b1; p.m1_sel = TS_CA; p.m2_en = 1'b1;
          p.m2_sel = TS_SE; p.neg = 1'b1; p.div_en = 1'b1; p.more = 1'b1;
        end else begin
          p.en = 1'b1; p.m1_en = 1'b1; p.m1_sel = TS_SA; p.to_el = 1'b1;
        end
      end
      K_NPAE: begin
        p.en = guard; p.m1_en = 1'b1; p.m1_sel = TS_SE; p.neg = 1'b1; p.div_en = 1'b1;
      end
      K_TF: begin
        p.en = 1'b1; p.m1_en = 1'b1; p.m1_sel = TS_CE; p.neg = 1'b1; p.to_el = 1'b1;
      end
      K_TX, K_TXL: begin
        p.en = 1'b1; p.m1_en = 1'b1; p.m1_sel = TS_CE; p.neg = 1'b1;
        p.div_en = 1'b1; p.div_se = 1'b1; p.to_el = 1'b1;
      end
      K_TX5, K_TX10, K_TX15: begin
        p.en = tx_ok; p.m1_en = 1'b1; p.m1_sel = TS_CE; p.neg = 1'b1;
        p.div_en = 1'b1; p.div_se = 1'b1; p.to_el = 1'b1;
      end
      K_HARM: begin
        p.en = (target != TGT_NONE); p.m1_en = 1'b1; p.m1_sel = TS_H1;
        p.m2_en = f2_on; p.m2_sel = TS_H2;
        p.div_en = (target == TGT_SIDE); p.to_el = (target == TGT_EL);
      end
      default: begin
        p.en = 1'b0;
      end
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/altaz_pointing_model_correction_core.sv
// altaz_pointing_model_correction_core: applies a stream of pointing-model terms
// to an alt-az position. Depends on azpm_pkg.
//
// One item at a time. A term runs its divisions on the bit-serial divider (three
// per term plus one per pass that divides), its angles through the iterative
// cordic and its factors through the serial multiplier. A result leaves through
// an output register.
// Synchronous reset clears the working position, group sums and flag.
module altaz_pointing_model_correction_core #(
  parameter int ANGLE_FRAC_BITS = azpm_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = azpm_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_new,
  input  logic [31:0] pos_az,
  input  logic [31:0] pos_el,
  input  logic [3:0]  term_kind,
  input  logic [31:0] coef_arcsec,
  input  logic [1:0]  harm_target,
  input  logic [1:0]  harm_factor1,
  input  logic [6:0]  harm_freq1,
  input  logic [2:0]  harm_factor2,
  input  logic [6:0]  harm_freq2,
  input  logic        group_end,
  input  logic        model_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] corr_az,
  output logic [31:0] corr_el,
  output logic        saturated
);

  localparam int ACC_W = azpm_pkg::ACC_W;
  localparam int T_W   = azpm_pkg::T_W;
  localparam int NUM_W = azpm_pkg::NUM_W;
  localparam int DEN_W = azpm_pkg::DEN_W;
  localparam int DM_W  = azpm_pkg::DM_W;
  localparam int Q_W   = azpm_pkg::Q_W;
  localparam int P_W   = azpm_pkg::P_W;
  localparam int SUM_W = azpm_pkg::SUM_W;
  localparam int DC_W  = azpm_pkg::DC_W;
  localparam int MC_W  = azpm_pkg::MC_W;
  localparam int CI_W  = $clog2(CORDIC_STEPS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CDIV  = 5'd1;
  localparam logic [4:0] S_PAZ   = 5'd2;
  localparam logic [4:0] S_PEL   = 5'd3;
  localparam logic [4:0] S_CORA  = 5'd4;
  localparam logic [4:0] S_CORE  = 5'd5;
  localparam logic [4:0] S_HARM1 = 5'd6;
  localparam logic [4:0] S_HARM2 = 5'd7;
  localparam logic [4:0] S_HARM3 = 5'd8;
  localparam logic [4:0] S_PASS  = 5'd9;
  localparam logic [4:0] S_M1    = 5'd10;
  localparam logic [4:0] S_M2    = 5'd11;
  localparam logic [4:0] S_NEG   = 5'd12;
  localparam logic [4:0] S_DV    = 5'd13;
  localparam logic [4:0] S_ACC   = 5'd14;
  localparam logic [4:0] S_END   = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;
  localparam logic [4:0] S_DIV   = 5'd17;
  localparam logic [4:0] S_DIVF  = 5'd18;
  localparam logic [4:0] S_MUL   = 5'd19;
  localparam logic [4:0] S_MULF  = 5'd20;
  localparam logic [4:0] S_COR   = 5'd21;
  localparam logic [4:0] S_CORF  = 5'd22;

  localparam logic signed [P_W-1:0] MUL_HALF = P_W'(64'd536870912);
  localparam logic signed [Q_W-1:0] DZ_POS   = Q_W'(64'sd2147483648);
  localparam logic signed [Q_W-1:0] DZ_NEG   = Q_W'(-64'sd2147483649);

  logic [4:0] state, ret;

  // latched item
  logic [3:0]  k_kind;
  logic [31:0] k_coef;
  logic [1:0]  k_tgt, k_f1;
  logic [2:0]  k_f2;
  logic [6:0]  k_fr1, k_fr2;
  logic        k_gend, k_mend;

  // model state
  logic signed [31:0]    work_az, work_el;
  logic signed [SUM_W-1:0] sum_az, sum_el;
  logic                  sat;

  logic                    pass_idx;
  logic signed [ACC_W-1:0] cval, acc;
  logic [31:0]             pa, pe;
  logic signed [T_W-1:0]   sa, ca, se, ce, h1, h2;

  // serial divider
  logic [DM_W-1:0]  dnum, dq;
  logic [DEN_W-1:0] drem, dden;
  logic [DC_W-1:0]  dcnt;
  logic             dneg, dn_neg, dzero;
  logic signed [Q_W-1:0] dres;

  // serial multiplier
  logic signed [ACC_W:0]  mcand;
  logic [T_W-1:0]         tmag;
  logic signed [P_W-1:0]  prod;
  logic [MC_W-1:0]        mcnt;

  // iterative cordic
  logic signed [T_W-1:0] cx, cy, cz;
  logic [CI_W-1:0]       ccnt;
  logic                  cflip;

  // control and operands
  azpm_pkg::pass_t plan;
  logic        f2_on, guard, tx_ok;
  logic [39:0] wel40, thr;
  logic        div_go, mul_go, cor_go;
  logic signed [NUM_W-1:0] div_n;
  logic signed [DEN_W-1:0] div_d;
  logic signed [T_W-1:0]   mul_t;
  logic [31:0] cor_p, hp1, hp2;

  assign in_ready = (state == S_IDLE);
  assign f2_on    = !k_f2[2];
  assign wel40    = {{8{work_el[31]}}, work_el};
  assign guard    = (wel40 != (40'd90 << ANGLE_FRAC_BITS)) &&
                    (wel40 != (40'd270 << ANGLE_FRAC_BITS));
  assign thr      = 40'(azpm_pkg::tx_floor_deg(k_kind)) << ANGLE_FRAC_BITS;
  assign tx_ok    = $signed(wel40) > $signed(thr);
  assign plan     = azpm_pkg::pass_plan(k_kind, pass_idx, guard, tx_ok, k_tgt, f2_on);
  assign hp1      = (k_f1[1] ? pe : pa) * 32'(k_fr1);
  assign hp2      = (k_f2[1] ? pe : pa) * 32'(k_fr2);

  function automatic logic signed [T_W-1:0] trig_pick(input logic [2:0] sel,
      input logic signed [T_W-1:0] vsa, input logic signed [T_W-1:0] vca,
      input logic signed [T_W-1:0] vse, input logic signed [T_W-1:0] vce,
      input logic signed [T_W-1:0] vh1, input logic signed [T_W-1:0] vh2);
    logic signed [T_W-1:0] t;
    case (sel)
      azpm_pkg::TS_SA: t = vsa;
      azpm_pkg::TS_CA: t = vca;
      azpm_pkg::TS_SE: t = vse;
      azpm_pkg::TS_CE: t = vce;
      azpm_pkg::TS_H1: t = vh1;
      default:         t = vh2;
    endcase
    return t;
  endfunction

  always_comb begin
    div_go = 1'b0;
    div_n  = '0;
    div_d  = $signed(azpm_pkg::PHASE_DIV);
    case (state)
      S_CDIV: begin
        div_go = 1'b1;
        div_n  = $signed({{(NUM_W-32){k_coef[31]}}, k_coef}) <<< ANGLE_FRAC_BITS;
        div_d  = $signed(azpm_pkg::COEF_DIV);
      end
      S_PAZ: begin
        div_go = 1'b1;
        div_n  = $signed({{(NUM_W-32){work_az[31]}}, work_az}) <<< (32 - ANGLE_FRAC_BITS);
      end
      S_PEL: begin
        div_go = 1'b1;
        div_n  = $signed({{(NUM_W-32){work_el[31]}}, work_el}) <<< (32 - ANGLE_FRAC_BITS);
      end
      S_DV: begin
        div_go = plan.div_en;
        div_n  = $signed({{(NUM_W-ACC_W){acc[ACC_W-1]}}, acc}) <<< 30;
        div_d  = plan.div_se ? se : ce;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  assign mul_go = ((state == S_M1) && plan.m1_en) || ((state == S_M2) && plan.m2_en);
  assign mul_t  = trig_pick((state == S_M1) ? plan.m1_sel : plan.m2_sel,
                            sa, ca, se, ce, h1, h2);

  always_comb begin
    case (state)
      S_CORA:  cor_p = pa;
      S_CORE:  cor_p = pe;
      S_HARM1: cor_p = hp1;
      default: cor_p = hp2;
    endcase
  end
  assign cor_go = (state == S_CORA) || (state == S_CORE) ||
                  ((state == S_HARM1) && (k_kind == azpm_pkg::K_HARM)) ||
                  ((state == S_HARM2) && f2_on);

  // divider step
  logic [DEN_W:0] d_r2;
  logic           d_fit;
  assign d_r2  = {drem, dnum[DM_W-1]};
  assign d_fit = d_r2 >= {1'b0, dden};

  // divider setup
  logic [NUM_W-1:0] d_un;
  logic [DEN_W-1:0] d_ud;
  assign d_un = div_n[NUM_W-1] ? NUM_W'(-div_n) : NUM_W'(div_n);
  assign d_ud = div_d[DEN_W-1] ? DEN_W'(-div_d) : DEN_W'(div_d);

  // multiplier rounding
  logic signed [P_W-1:0] mul_rnd;
  logic signed [ACC_W:0] acc_ext;
  assign mul_rnd = (prod + MUL_HALF) >>> 30;
  assign acc_ext = {acc[ACC_W-1], acc};

  // cordic step
  logic signed [T_W-1:0] cx_sh, cy_sh, c_at;
  logic [31:0]           c_padd;
  logic [31:0]           c_pp;
  assign cx_sh  = cx >>> ccnt;
  assign cy_sh  = cy >>> ccnt;
  assign c_at   = $signed({2'b00, azpm_pkg::atan_entry(5'(ccnt))});
  assign c_padd = cor_p + 32'h40000000;
  assign c_pp   = {cor_p[31] ^ c_padd[31], cor_p[30:0]};

  // term clamp and accumulate
  logic                   tv_hi, tv_lo;
  logic signed [31:0]     tv;
  logic signed [SUM_W:0]  tsum;
  logic signed [SUM_W-1:0] tsum_sat;
  assign tv_hi = !dres[Q_W-1] && (|dres[Q_W-2:31]);
  assign tv_lo = dres[Q_W-1] && !(&dres[Q_W-2:31]);
  assign tv    = tv_hi ? 32'sh7FFFFFFF : (tv_lo ? 32'sh80000000 : dres[31:0]);
  assign tsum  = {(plan.to_el ? sum_el[SUM_W-1] : sum_az[SUM_W-1]),
                  (plan.to_el ? sum_el : sum_az)} + {{(SUM_W-31){tv[31]}}, tv};
  assign tsum_sat = (tsum[SUM_W] != tsum[SUM_W-1]) ?
                    (tsum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}}) :
                    tsum[SUM_W-1:0];

  // position update at group or model end
  logic signed [SUM_W:0] upd_az, upd_el;
  logic                  az_ovf, el_ovf;
  logic signed [31:0]    new_az, new_el;
  assign upd_az = {{(SUM_W-31){work_az[31]}}, work_az} - {sum_az[SUM_W-1], sum_az};
  assign upd_el = {{(SUM_W-31){work_el[31]}}, work_el} - {sum_el[SUM_W-1], sum_el};
  assign az_ovf = !((&upd_az[SUM_W:31]) || !(|upd_az[SUM_W:31]));
  assign el_ovf = !((&upd_el[SUM_W:31]) || !(|upd_el[SUM_W:31]));
  assign new_az = az_ovf ? (upd_az[SUM_W] ? 32'sh80000000 : 32'sh7FFFFFFF) : upd_az[31:0];
  assign new_el = el_ovf ? (upd_el[SUM_W] ? 32'sh80000000 : 32'sh7FFFFFFF) : upd_el[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
      work_az   <= '0;
      work_el   <= '0;
      sum_az    <= '0;
      sum_el    <= '0;
      sat       <= 1'b0;
      pass_idx  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            k_kind <= term_kind;
            k_coef <= coef_arcsec;
            k_tgt  <= harm_target;
            k_f1   <= harm_factor1;
            k_fr1  <= harm_freq1;
            k_f2   <= harm_factor2;
            k_fr2  <= harm_freq2;
            k_gend <= group_end;
            k_mend <= model_end;
            pass_idx <= 1'b0;
            if (start_new) begin
              work_az <= pos_az;
              work_el <= pos_el;
              sum_az  <= '0;
              sum_el  <= '0;
              sat     <= 1'b0;
            end
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          ret <= S_PAZ; state <= S_DIV;
        end
        S_PAZ: begin
          cval <= dres[ACC_W-1:0];
          ret <= S_PEL; state <= S_DIV;
        end
        S_PEL: begin
          pa <= dres[31:0];
          ret <= S_CORA; state <= S_DIV;
        end
        S_CORA: begin
          pe <= dres[31:0];
          ret <= S_CORE; state <= S_COR;
        end
        S_CORE: begin
          sa <= cy; ca <= cx;
          ret <= S_HARM1; state <= S_COR;
        end
        S_HARM1: begin
          se <= cy; ce <= cx;
          if (k_kind == azpm_pkg::K_HARM) begin
            ret <= S_HARM2; state <= S_COR;
          end else begin
            state <= S_PASS;
          end
        end
        S_HARM2: begin
          h1 <= k_f1[0] ? cy : cx;
          if (f2_on) begin
            ret <= S_HARM3; state <= S_COR;
          end else begin
            state <= S_PASS;
          end
        end
        S_HARM3: begin
          h2 <= k_f2[0] ? cy : cx;
          state <= S_PASS;
        end
        S_PASS: begin
          acc <= cval;
          if (plan.en) begin
            state <= S_M1;
          end else if (plan.more) begin
            pass_idx <= 1'b1;
          end else begin
            state <= S_END;
          end
        end
        S_M1: begin
          if (plan.m1_en) begin
            ret <= S_M2; state <= S_MUL;
          end else begin
            state <= S_M2;
          end
        end
        S_M2: begin
          if (plan.m2_en) begin
            ret <= S_NEG; state <= S_MUL;
          end else begin
            state <= S_NEG;
          end
        end
        S_NEG: begin
          if (plan.neg) begin
            acc <= -acc;
          end
          state <= S_DV;
        end
        S_DV: begin
          if (plan.div_en) begin
            ret <= S_ACC; state <= S_DIV;
          end else begin
            dres  <= $signed({{(Q_W-ACC_W){acc[ACC_W-1]}}, acc});
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (tv_hi || tv_lo || (tsum[SUM_W] != tsum[SUM_W-1])) begin
            sat <= 1'b1;
          end
          if (plan.to_el) begin
            sum_el <= tsum_sat;
          end else begin
            sum_az <= tsum_sat;
          end
          if (plan.more) begin
            pass_idx <= 1'b1;
            state    <= S_PASS;
          end else begin
            state <= S_END;
          end
        end
        S_END: begin
          if (k_gend || k_mend) begin
            work_az <= new_az;
            work_el <= new_el;
            sum_az  <= '0;
            sum_el  <= '0;
            if (az_ovf || el_ovf) begin
              sat <= 1'b1;
            end
          end
          state <= k_mend ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            corr_az   <= work_az;
            corr_el   <= work_el;
            saturated <= sat;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (d_fit) begin
            drem <= DEN_W'(d_r2 - {1'b0, dden});
          end else begin
            drem <= d_r2[DEN_W-1:0];
          end
          dnum <= {dnum[DM_W-2:0], 1'b0};
          dq   <= {dq[DM_W-2:0], d_fit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DC_W'(DM_W - 1)) begin
            state <= S_DIVF;
          end
        end
        S_DIVF: begin
          if (dzero) begin
            sat  <= 1'b1;
            dres <= dn_neg ? DZ_NEG : DZ_POS;
          end else begin
            dres <= dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
          end
          state <= ret;
        end
        S_MUL: begin
          prod <= (prod <<< 1) +
                  (tmag[T_W-1] ? $signed({{(P_W-ACC_W-1){mcand[ACC_W]}}, mcand}) :
                                 $signed(P_W'(0)));
          tmag <= {tmag[T_W-2:0], 1'b0};
          mcnt <= mcnt + 1'b1;
          if (mcnt == MC_W'(T_W - 1)) begin
            state <= S_MULF;
          end
        end
        S_MULF: begin
          acc   <= mul_rnd[ACC_W-1:0];
          state <= ret;
        end
        S_COR: begin
          if (!cz[T_W-1]) begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - c_at;
          end else begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + c_at;
          end
          ccnt <= ccnt + 1'b1;
          if (ccnt == CI_W'(CORDIC_STEPS - 1)) begin
            state <= S_CORF;
          end
        end
        S_CORF: begin
          if (cflip) begin
            cx <= -cx;
            cy <= -cy;
          end
          state <= ret;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // shared unit loads
      if (div_go) begin
        dnum   <= {1'b0, d_un} + {{(DM_W-DEN_W+1){1'b0}}, d_ud[DEN_W-1:1]};
        drem   <= '0;
        dq     <= '0;
        dden   <= d_ud;
        dcnt   <= '0;
        dn_neg <= div_n[NUM_W-1];
        dneg   <= div_n[NUM_W-1] ^ div_d[DEN_W-1];
        dzero  <= (div_d == '0);
      end
      if (mul_go) begin
        mcand <= mul_t[T_W-1] ? -acc_ext : acc_ext;
        tmag  <= mul_t[T_W-1] ? T_W'(-mul_t) : T_W'(mul_t);
        prod  <= '0;
        mcnt  <= '0;
      end
      if (cor_go) begin
        cflip <= c_padd[31];
        cz    <= $signed({{(T_W-32){c_pp[31]}}, c_pp});
        cx    <= azpm_pkg::CORDIC_X0;
        cy    <= '0;
        ccnt  <= '0;
      end
    end
  end

  // a zero divisor always leaves the saturation flag set
  a_divzero_sat: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVF && dzero) |=> sat)
    else $error("zero divisor did not set saturation flag");

  // group sums are cleared after a group or model end
  a_group_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_END && (k_gend || k_mend)) |=> (sum_az == '0 && sum_el == '0))
    else $error("group sums not cleared at group end");

  // a result only appears from the output state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

endmodule
